>>> hw/rtl/p11of_pkg.sv
package p11of_pkg;

   localparam int MEM_WORDS_DEF = 32768;

   localparam logic [15:0] WORD_MASK = 16'o177777;
   localparam logic [2:0]  REG_MASK  = 3'o7;
   localparam logic [2:0]  PC_REG    = 3'd7;
   localparam logic [15:0] STEP_TWO  = 16'd2;

   localparam logic [1:0] ACT_REG_WRITE = 2'd0;
   localparam logic [1:0] ACT_MEM_WRITE = 2'd1;
   localparam logic [1:0] ACT_FETCH     = 2'd2;

   localparam logic [2:0] MODE_REG          = 3'd0;
   localparam logic [2:0] MODE_REG_DEF      = 3'd1;
   localparam logic [2:0] MODE_AUTOINC      = 3'd2;
   localparam logic [2:0] MODE_AUTOINC_DEF  = 3'd3;
   localparam logic [2:0] MODE_AUTODEC      = 3'd4;
   localparam logic [2:0] MODE_AUTODEC_DEF  = 3'd5;

   localparam int UPC_W = 4;

   localparam logic [UPC_W-1:0] UA_REG_WRITE = 4'd0;
   localparam logic [UPC_W-1:0] UA_MEM_WRITE = 4'd1;
   localparam logic [UPC_W-1:0] UA_NOP       = 4'd2;
   localparam logic [UPC_W-1:0] UA_MODE0     = 4'd3;
   localparam logic [UPC_W-1:0] UA_MODE1     = 4'd4;
   localparam logic [UPC_W-1:0] UA_MODE23    = 4'd5;
   localparam logic [UPC_W-1:0] UA_READ_PC   = 4'd6;
   localparam logic [UPC_W-1:0] UA_MODE45    = 4'd7;
   localparam logic [UPC_W-1:0] UA_READ      = 4'd8;
   localparam logic [UPC_W-1:0] UA_VALUE     = 4'd9;
   localparam logic [UPC_W-1:0] UA_INDIRECT  = 4'd10;
   localparam logic [UPC_W-1:0] UA_READ2     = 4'd11;
   localparam logic [UPC_W-1:0] UA_LAST      = UA_READ2;

   localparam logic [1:0] EA_NONE  = 2'd0;
   localparam logic [1:0] EA_REG   = 2'd1;
   localparam logic [1:0] EA_DEC   = 2'd2;
   localparam logic [1:0] EA_RDATA = 2'd3;

   localparam logic [1:0] VAL_NONE  = 2'd0;
   localparam logic [1:0] VAL_REG   = 2'd1;
   localparam logic [1:0] VAL_RDATA = 2'd2;

   localparam logic [1:0] ROP_NONE = 2'd0;
   localparam logic [1:0] ROP_DATA = 2'd1;
   localparam logic [1:0] ROP_INC  = 2'd2;
   localparam logic [1:0] ROP_DEC  = 2'd3;

   typedef struct packed {
      logic [1:0]       action;
      logic [2:0]       register_select;
      logic [2:0]       mode;
      logic [14:0]      word_index;
      logic [15:0]      data_word;
   } req_type;

   typedef struct packed {
      logic [15:0]      effective_address;
      logic [15:0]      operand_value;
      logic [31:0]      read_count;
      logic [31:0]      fetch_count;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       ea_ld;
      logic [1:0]       val_ld;
      logic [1:0]       reg_op;
      logic             mem_wr;
      logic             mem_rd;
      logic             cnt_pc;
      logic             br_dbl;
      logic             last;
      logic [UPC_W-1:0] nxt;
      logic [UPC_W-1:0] alt;
   } cw_type;

   function automatic logic [UPC_W-1:0] dispatch(input logic [1:0] action,
                                                 input logic [2:0] mode);
      logic [UPC_W-1:0] a;
      a = UA_NOP;
      priority if (action == ACT_REG_WRITE) begin
         a = UA_REG_WRITE;
      end else if (action == ACT_MEM_WRITE) begin
         a = UA_MEM_WRITE;
      end else if (action == ACT_FETCH) begin
         unique case (mode)
            MODE_REG:                       a = UA_MODE0;
            MODE_REG_DEF:                   a = UA_MODE1;
            MODE_AUTOINC, MODE_AUTOINC_DEF: a = UA_MODE23;
            MODE_AUTODEC, MODE_AUTODEC_DEF: a = UA_MODE45;
            default:                        a = UA_NOP;
         endcase
      end else begin
         a = UA_NOP;
      end
      return a;
   endfunction

   function automatic cw_type rom_word(input logic [UPC_W-1:0] a);
      cw_type w;
      w = '0;
      unique case (a)
         UA_REG_WRITE: begin
            w.reg_op = ROP_DATA;
            w.last   = 1'b1;
         end
         UA_MEM_WRITE: begin
            w.mem_wr = 1'b1;
            w.last   = 1'b1;
         end
         UA_MODE0: begin
            w.val_ld = VAL_REG;
            w.last   = 1'b1;
         end
         UA_MODE1: begin
            w.ea_ld = EA_REG;
            w.nxt   = UA_READ;
         end
         UA_MODE23: begin
            w.ea_ld  = EA_REG;
            w.reg_op = ROP_INC;
            w.nxt    = UA_READ_PC;
         end
         UA_READ_PC: begin
            w.mem_rd = 1'b1;
            w.cnt_pc = 1'b1;
            w.br_dbl = 1'b1;
            w.nxt    = UA_VALUE;
            w.alt    = UA_INDIRECT;
         end
         UA_MODE45: begin
            w.ea_ld  = EA_DEC;
            w.reg_op = ROP_DEC;
            w.nxt    = UA_READ;
         end
         UA_READ: begin
            w.mem_rd = 1'b1;
            w.br_dbl = 1'b1;
            w.nxt    = UA_VALUE;
            w.alt    = UA_INDIRECT;
         end
         UA_VALUE: begin
            w.val_ld = VAL_RDATA;
            w.last   = 1'b1;
         end
         UA_INDIRECT: begin
            w.ea_ld = EA_RDATA;
            w.nxt   = UA_READ2;
         end
         UA_READ2: begin
            w.mem_rd = 1'b1;
            w.nxt    = UA_VALUE;
         end
         default: begin
            w.last = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

>>> hw/rtl/p11of_if.sv
interface p11of_req_if;
   import p11of_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface p11of_rsp_if;
   import p11of_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/pdp11_operand_fetch.sv
// Program length: register and memory writes, register mode and modes 6/7 run one
// microcode step; modes 1, 2 and 4 run three; modes 3 and 5 run five. The
// response word is registered and appears the cycle after the last step.
// A new request word is taken in the program's last step, which waits while an
// earlier response is still held; the single-port word memory takes one access per step.
// Reset (synchronous): registers and counts clear to zero, memory is untouched.
module pdp11_operand_fetch #(
   parameter int MEM_WORDS = p11of_pkg::MEM_WORDS_DEF
) (
   input logic          clock,
   input logic          reset,
   p11of_req_if.sink    req_chan,
   p11of_rsp_if.source  rsp_chan
);
   import p11of_pkg::*;

   localparam int IDX_W = $clog2(MEM_WORDS);
   localparam int QB    = 16 - IDX_W;

   function automatic logic [IDX_W-1:0] word_mod(input logic [14:0] x);
      logic [15:0] rem;
      rem = {1'b0, x};
      for (int k = QB - 1; k >= 0; k--) begin
         if (rem >= 16'(MEM_WORDS << k)) begin
            rem = rem - 16'(MEM_WORDS << k);
         end
      end
      return rem[IDX_W-1:0];
   endfunction

   logic [15:0]      regs_ff [8];
   logic [15:0]      mem [MEM_WORDS];
   logic [15:0]      rdata_ff;
   req_type          req_ff;
   logic             busy_ff, busy_in;
   logic [UPC_W-1:0] upc_ff, upc_in;
   logic [15:0]      ea_ff, ea_in;
   logic [15:0]      val_ff, val_in;
   logic [31:0]      rc_ff, rc_in;
   logic [31:0]      fc_ff, fc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   cw_type           cw;
   logic             step_en;
   logic             accept;
   logic             dbl;
   logic [15:0]      reg_rd;
   logic [IDX_W-1:0] mem_idx;

   assign cw      = rom_word(upc_ff);
   assign step_en = busy_ff & (~cw.last | ~rsp_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~busy_ff | (step_en & cw.last);
   assign accept  = req_chan.valid & req_chan.ready;
   assign dbl     = (req_ff.mode == MODE_AUTOINC_DEF) || (req_ff.mode == MODE_AUTODEC_DEF);
   assign reg_rd  = regs_ff[req_ff.register_select & REG_MASK];
   assign mem_idx = word_mod(cw.mem_wr ? req_ff.word_index : ea_ff[15:1]);

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_comb begin
      busy_in      = busy_ff;
      upc_in       = upc_ff;
      ea_in        = ea_ff;
      val_in       = val_ff;
      rc_in        = rc_ff;
      fc_in        = fc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (step_en) begin
         unique case (cw.ea_ld)
            EA_REG:   ea_in = reg_rd;
            EA_DEC:   ea_in = (reg_rd - STEP_TWO) & WORD_MASK;
            EA_RDATA: ea_in = rdata_ff;
            default:  ea_in = ea_ff;
         endcase
         unique case (cw.val_ld)
            VAL_REG:   val_in = reg_rd;
            VAL_RDATA: val_in = rdata_ff;
            default:   val_in = val_ff;
         endcase
         if (cw.mem_rd) begin
            if (cw.cnt_pc && (req_ff.register_select == PC_REG)) begin
               fc_in = fc_ff + 32'd1;
            end else begin
               rc_in = rc_ff + 32'd1;
            end
         end
         upc_in = (cw.br_dbl && dbl) ? cw.alt : cw.nxt;
         if (cw.last) begin
            busy_in                  = 1'b0;
            rsp_valid_in             = 1'b1;
            rsp_in.effective_address = ea_in;
            rsp_in.operand_value     = val_in;
            rsp_in.read_count        = rc_in;
            rsp_in.fetch_count       = fc_in;
         end
      end

      if (accept) begin
         busy_in = 1'b1;
         upc_in  = dispatch(req_chan.payload.action, req_chan.payload.mode);
         ea_in   = '0;
         val_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         upc_ff       <= UA_NOP;
         rc_ff        <= '0;
         fc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         busy_ff      <= busy_in;
         upc_ff       <= upc_in;
         rc_ff        <= rc_in;
         fc_ff        <= fc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step_en) begin
            unique case (cw.reg_op)
               ROP_DATA: regs_ff[req_ff.register_select] <= req_ff.data_word;
               ROP_INC:  regs_ff[req_ff.register_select] <= (reg_rd + STEP_TWO) & WORD_MASK;
               ROP_DEC:  regs_ff[req_ff.register_select] <= (reg_rd - STEP_TWO) & WORD_MASK;
               default:  ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ea_ff  <= ea_in;
      val_ff <= val_in;
      rsp_ff <= rsp_in;
      if (accept) begin
         req_ff <= req_chan.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && cw.mem_wr) begin
         mem[mem_idx] <= req_ff.data_word;
      end
      if (step_en && cw.mem_rd) begin
         rdata_ff <= mem[mem_idx];
      end
   end

   a_upc_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (upc_ff <= UA_LAST))
      else $error("microcode address beyond program");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !(step_en && cw.mem_rd) |=> ($stable(rc_ff) && $stable(fc_ff)))
      else $error("count moved without a memory read");

   a_one_count: assert property (@(posedge clock) disable iff (reset)
      (step_en && cw.mem_rd) |=> ($stable(rc_ff) != $stable(fc_ff)))
      else $error("memory read must bump exactly one count");

   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff))
      else $error("response without a running program");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("accepted word did not start the sequencer");

endmodule
